FILE: src/mbe_pkg.sv
// shared constants, types and arithmetic helpers of the escape-time block
package mbe_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int COORD_BITS = 12;
    localparam int REG_FRAC   = 28;
    localparam int REG_W      = 32;
    localparam int PIX_W      = 12;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 3;

    localparam int ZW    = FRAC_BITS + 4;
    localparam int MUL_W = (ZW > REG_W) ? ZW : REG_W;
    localparam int PW    = 2 * MUL_W;
    localparam int QW    = PW - FRAC_BITS;
    localparam int TW    = QW + 2;

    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

    localparam logic signed [REG_W-1:0] RST_X_ORIGIN = -32'sd536870912;
    localparam logic signed [REG_W-1:0] RST_Y_ORIGIN = 32'sd56371446;
    localparam logic signed [REG_W-1:0] RST_X_STEP   = 32'sd1048576;
    localparam logic signed [REG_W-1:0] RST_Y_STEP   = -32'sd1048576;
    localparam logic [CNT_W-1:0]        RST_MAX_ITER = 16'd256;

    typedef struct packed {
        logic signed [REG_W-1:0] x_origin;
        logic signed [REG_W-1:0] y_origin;
        logic signed [REG_W-1:0] x_step;
        logic signed [REG_W-1:0] y_step;
        logic [CNT_W-1:0]        max_iter;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             escaped;
    } t_res;

    typedef struct packed {
        logic signed [MUL_W-1:0] a0;
        logic signed [MUL_W-1:0] b0;
        logic signed [MUL_W-1:0] a1;
        logic signed [MUL_W-1:0] b1;
        logic signed [MUL_W-1:0] a2;
        logic signed [MUL_W-1:0] b2;
    } t_mul_op;

    typedef struct packed {
        logic signed [PW-1:0] p0;
        logic signed [PW-1:0] p1;
        logic signed [PW-1:0] p2;
    } t_mul_prod;

    // clamp an exact origin + k * step sum to the signed register range
    function automatic logic signed [REG_W-1:0] sat_reg(input logic signed [PW:0] s);
        logic signed [REG_W-1:0] r;
        if ((&s[PW:REG_W-1]) || !(|s[PW:REG_W-1])) begin
            r = s[REG_W-1:0];
        end else if (s[PW]) begin
            r = {1'b1, {(REG_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(REG_W-1){1'b1}}};
        end
        return r;
    endfunction

    // register format to z format, floor on a right shift
    function automatic logic signed [ZW-1:0] rescale(input logic signed [REG_W-1:0] v);
        logic signed [REG_W+ZW-1:0] w;
        w = {{ZW{v[REG_W-1]}}, v};
        if (FRAC_BITS >= REG_FRAC) begin
            w = w <<< (FRAC_BITS - REG_FRAC);
        end else begin
            w = w >>> (REG_FRAC - FRAC_BITS);
        end
        return w[ZW-1:0];
    endfunction

    // clamp an updated z part to [-8.0, 8.0 - lsb]
    function automatic logic signed [ZW-1:0] sat_z(input logic signed [TW-1:0] t);
        logic signed [ZW-1:0] r;
        if ((&t[TW-1:ZW-1]) || !(|t[TW-1:ZW-1])) begin
            r = t[ZW-1:0];
        end else if (t[TW-1]) begin
            r = {1'b1, {(ZW-1){1'b0}}};
        end else begin
            r = {1'b0, {(ZW-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

FILE: src/mbe_pix_if.sv
// pixel coordinate channel
interface mbe_pix_if;
    logic                    valid;
    logic                    ready;
    logic [mbe_pkg::PIX_W-1:0] pixel_x;
    logic [mbe_pkg::PIX_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

FILE: src/mbe_res_if.sv
// escape result channel
interface mbe_res_if;
    logic                    valid;
    logic                    ready;
    logic [mbe_pkg::CNT_W-1:0] iteration_count;
    logic                    escaped;

    modport source (output valid, output iteration_count, output escaped, input ready);
    modport sink   (input valid, input iteration_count, input escaped, output ready);
endinterface

FILE: src/mbe_mul.sv
// shared triple multiplier with registered products
module mbe_mul (
    input  logic               i_clk,
    input  mbe_pkg::t_mul_op   i_op,
    output mbe_pkg::t_mul_prod o_prod
);

    mbe_pkg::t_mul_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod.p0 <= $signed(i_op.a0) * $signed(i_op.b0);
        r_prod.p1 <= $signed(i_op.a1) * $signed(i_op.b1);
        r_prod.p2 <= $signed(i_op.a2) * $signed(i_op.b2);
    end

    assign o_prod = r_prod;

endmodule

FILE: src/mbe_core.sv
// sequencer and z datapath around the shared multiplier
module mbe_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mbe_pkg::t_cfg               i_cfg,
    input  logic                        i_start,
    input  logic [mbe_pkg::PIX_W-1:0]   i_pixel_x,
    input  logic [mbe_pkg::PIX_W-1:0]   i_pixel_y,
    output logic                        o_idle,
    output logic                        o_done,
    output mbe_pkg::t_res               o_res,
    input  logic                        i_take
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMUL  = 3'd1;
    localparam logic [2:0] S_CFORM = 3'd2;
    localparam logic [2:0] S_SQ    = 3'd3;
    localparam logic [2:0] S_TEST  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam int QW = mbe_pkg::QW;
    localparam int TW = mbe_pkg::TW;
    localparam int ZW = mbe_pkg::ZW;
    localparam int PW = mbe_pkg::PW;

    logic [2:0] r_state, n_state;
    logic [mbe_pkg::COORD_BITS-1:0] r_kx, r_ky;
    logic signed [ZW-1:0] r_cr, r_ci, r_zr, r_zi;
    logic [mbe_pkg::CNT_W-1:0] r_n;
    logic r_esc;

    mbe_pkg::t_mul_op   mul_op;
    mbe_pkg::t_mul_prod mul_prod;

    logic signed [QW-1:0] rr, ii, ri;
    logic signed [QW:0]   mag;
    logic signed [QW:0]   four;
    logic                 escape;
    logic signed [TW-1:0] zr_t, zi_t;
    logic signed [PW:0]   cx_s, cy_s;
    logic                 at_limit;

    mbe_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (mul_op),
        .o_prod (mul_prod)
    );

    // operand select: coordinate products while forming c, else the square of z
    always_comb begin
        if (r_state == S_CMUL) begin
            mul_op.a0 = {{(mbe_pkg::MUL_W-mbe_pkg::COORD_BITS){1'b0}}, r_kx};
            mul_op.b0 = mbe_pkg::MUL_W'(i_cfg.x_step);
            mul_op.a1 = {{(mbe_pkg::MUL_W-mbe_pkg::COORD_BITS){1'b0}}, r_ky};
            mul_op.b1 = mbe_pkg::MUL_W'(i_cfg.y_step);
        end else begin
            mul_op.a0 = mbe_pkg::MUL_W'(r_zr);
            mul_op.b0 = mbe_pkg::MUL_W'(r_zr);
            mul_op.a1 = mbe_pkg::MUL_W'(r_zi);
            mul_op.b1 = mbe_pkg::MUL_W'(r_zi);
        end
        mul_op.a2 = mbe_pkg::MUL_W'(r_zr);
        mul_op.b2 = mbe_pkg::MUL_W'(r_zi);
    end

    // products reduced by the fraction width, floor rounding
    assign rr   = mul_prod.p0[PW-1:mbe_pkg::FRAC_BITS];
    assign ii   = mul_prod.p1[PW-1:mbe_pkg::FRAC_BITS];
    assign ri   = mul_prod.p2[PW-1:mbe_pkg::FRAC_BITS];
    assign mag  = {rr[QW-1], rr} + {ii[QW-1], ii};
    assign four = (QW+1)'(1) << (mbe_pkg::FRAC_BITS + 2);
    assign escape = (mag >= four);

    assign zr_t = {{2{rr[QW-1]}}, rr} - {{2{ii[QW-1]}}, ii}
                + {{(TW-ZW){r_cr[ZW-1]}}, r_cr};
    assign zi_t = {ri[QW-1], ri, 1'b0} + {{(TW-ZW){r_ci[ZW-1]}}, r_ci};

    assign cx_s = {mul_prod.p0[PW-1], mul_prod.p0}
                + {{(PW+1-mbe_pkg::REG_W){i_cfg.x_origin[mbe_pkg::REG_W-1]}}, i_cfg.x_origin};
    assign cy_s = {mul_prod.p1[PW-1], mul_prod.p1}
                + {{(PW+1-mbe_pkg::REG_W){i_cfg.y_origin[mbe_pkg::REG_W-1]}}, i_cfg.y_origin};

    assign at_limit = (r_n == i_cfg.max_iter);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_CMUL;
            S_CMUL:  n_state = S_CFORM;
            S_CFORM: n_state = S_SQ;
            S_SQ:    n_state = at_limit ? S_DONE : S_TEST;
            S_TEST:  n_state = escape ? S_DONE : S_SQ;
            S_DONE:  if (i_take) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_kx <= i_pixel_x[mbe_pkg::COORD_BITS-1:0];
                r_ky <= i_pixel_y[mbe_pkg::COORD_BITS-1:0];
            end
            S_CFORM: begin
                r_cr  <= mbe_pkg::rescale(mbe_pkg::sat_reg(cx_s));
                r_ci  <= mbe_pkg::rescale(mbe_pkg::sat_reg(cy_s));
                r_zr  <= '0;
                r_zi  <= '0;
                r_n   <= '0;
                r_esc <= 1'b0;
            end
            S_TEST: begin
                if (escape) begin
                    r_esc <= 1'b1;
                end else begin
                    r_zr <= mbe_pkg::sat_z(zr_t);
                    r_zi <= mbe_pkg::sat_z(zi_t);
                    r_n  <= r_n + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_idle        = (r_state == S_IDLE);
    assign o_done        = (r_state == S_DONE);
    assign o_res.count   = r_n;
    assign o_res.escaped = r_esc;

    // an update is only tested below the limit
    a_test_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TEST) |-> (r_n < i_cfg.max_iter))
        else $error("z test reached with count at limit");

    // a result without escape only comes from the limit
    a_limit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_esc) |-> (r_n == i_cfg.max_iter))
        else $error("inside result below the limit");

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !i_take) |=> (o_done && $stable(r_n) && $stable(r_esc)))
        else $error("result changed while waiting");

    // each pixel starts with a cleared count
    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CFORM) |=> (r_n == '0 && !r_esc))
        else $error("count not cleared at pixel start");

endmodule

FILE: src/mandelbrot_escape_time.sv
// top level of the mandelbrot escape-time block
//
// usage
//   i_pix carries one pixel (pixel_x, pixel_y) per item; o_res returns one item
//   per pixel: iteration_count and escaped, in input order
//   config registers are written through i_cfg_we / i_cfg_idx / i_cfg_data by
//   the user while the block is idle (unenforced); unknown indexes are ignored
// timing
//   one shared set of three multipliers does each z update in the states S_SQ
//   (square products), then S_TEST (escape test and z update)
//   an accepted pixel passes S_CMUL and S_CFORM, then S_SQ and S_TEST for each
//   z update, then waits in S_DONE until the output register takes it; the
//   sequencer takes no new pixel until the last one has left S_DONE
//   i_pix.ready is high only while the sequencer is idle
// reset
//   synchronous active-low i_rst_n clears the sequencer and output valid and
//   loads the register defaults (view around -2.0 + 0.21i, step 1/256, limit 256)
// stall
//   the finished item sits in an output register; the next pixel is taken
//   while it waits, and a second result holds in the core until o_res drains
module mandelbrot_escape_time (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mbe_pkg::REG_W-1:0]        i_cfg_data,
    mbe_pix_if.sink                          i_pix,
    mbe_res_if.source                        o_res
);

    mbe_pkg::t_cfg r_cfg;
    mbe_pkg::t_res r_out;
    mbe_pkg::t_res core_res;
    logic          r_out_valid;
    logic          core_idle;
    logic          core_done;
    logic          take;
    logic          accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_origin <= mbe_pkg::RST_X_ORIGIN;
            r_cfg.y_origin <= mbe_pkg::RST_Y_ORIGIN;
            r_cfg.x_step   <= mbe_pkg::RST_X_STEP;
            r_cfg.y_step   <= mbe_pkg::RST_Y_STEP;
            r_cfg.max_iter <= mbe_pkg::RST_MAX_ITER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mbe_pkg::REG_X_ORIGIN: r_cfg.x_origin <= i_cfg_data;
                mbe_pkg::REG_Y_ORIGIN: r_cfg.y_origin <= i_cfg_data;
                mbe_pkg::REG_X_STEP:   r_cfg.x_step   <= i_cfg_data;
                mbe_pkg::REG_Y_STEP:   r_cfg.y_step   <= i_cfg_data;
                mbe_pkg::REG_MAX_ITER: r_cfg.max_iter <= i_cfg_data[mbe_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // a pixel is taken whenever the sequencer is idle
    assign i_pix.ready = core_idle;
    assign accept      = i_pix.valid && core_idle;

    mbe_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_start   (accept),
        .i_pixel_x (i_pix.pixel_x),
        .i_pixel_y (i_pix.pixel_y),
        .o_idle    (core_idle),
        .o_done    (core_done),
        .o_res     (core_res),
        .i_take    (take)
    );

    // output register moves a finished item on when it is empty or draining
    assign take = core_done && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.iteration_count = r_out.count;
    assign o_res.escaped         = r_out.escaped;

endmodule
